@@ design/rsgp_pkg.sv @@
// ----------------------------------------------------------------------------
// rsgp_pkg
// Shared sizes for the Reed-Solomon generator polynomial builder.
// ----------------------------------------------------------------------------
package rsgp_pkg;

  localparam int MAX_T = 16;
  localparam int MAX_M = 10;

  localparam int TBL_DEPTH  = 1 << MAX_M;
  localparam int ELEM_W     = MAX_M;
  localparam int M_W        = $clog2(MAX_M + 1);
  localparam int COEF_DEPTH = 2 * MAX_T + 1;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);

  localparam int T_W   = 6;
  localparam int LOG_W = 11;
  localparam int POW_W = 6;
  localparam int FD_W  = 4;
  localparam int PP_W  = 11;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_DEGREE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIMITIVE_POLY = 1'b1;

  localparam logic [FD_W-1:0] FD_RESET = 4'd8;
  localparam logic [PP_W-1:0] PP_RESET = 11'd285;

endpackage

@@ design/rsgp_ram.sv @@
// ----------------------------------------------------------------------------
// rsgp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rsgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rs_generator_polynomial.sv @@
// ----------------------------------------------------------------------------
// rs_generator_polynomial
// Builds g(x) = (x + a^1)...(x + a^2t) over GF(2^m) and streams its
// coefficients in log form, lowest power first.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  in_      slave      correction_power t
//  out_     master     coeff_log, coeff_power; status in tuser; last in tlast
//  cfg_     slave      index 0 field_degree, index 1 primitive_poly
//
//  After reset or any register write the first item with a valid t rebuilds
//  the power and log tables (n = 2^m - 1), clearing the log RAM on the way.
//  In the product each multiply-accumulate is a coefficient RAM read, a log
//  read, the shared mod-n adder and a power read. Each coefficient is then
//  emitted after a coefficient RAM read and a log read. An invalid t gives
//  one error item with status and tlast set. Output stalls hold the
//  sequencer; in_tready is high only while idle.
// ----------------------------------------------------------------------------
module rs_generator_polynomial (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rsgp_pkg::IN_TDATA_W-1:0]  in_tdata,   // [5:0] correction_power
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rsgp_pkg::OUT_TDATA_W-1:0] out_tdata,  // [10:0] coeff_log, [16:11] coeff_power
  output logic                             out_tuser,  // [0] status
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rsgp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsgp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rsgp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;
  localparam logic [3:0] S_TFWD = 4'd2;
  localparam logic [3:0] S_TREV = 4'd3;
  localparam logic [3:0] S_INIT = 4'd4;
  localparam logic [3:0] S_ONE  = 4'd5;
  localparam logic [3:0] S_R0   = 4'd6;
  localparam logic [3:0] S_R1   = 4'd7;
  localparam logic [3:0] S_R2   = 4'd8;
  localparam logic [3:0] S_R3   = 4'd9;
  localparam logic [3:0] S_E0   = 4'd10;
  localparam logic [3:0] S_E1   = 4'd11;
  localparam logic [3:0] S_E2   = 4'd12;

  logic [3:0]         state_r, state_nxt;
  logic [FD_W-1:0]    fd_r, fd_nxt;
  logic [PP_W-1:0]    pp_r, pp_nxt;
  logic               tables_ok_r, tables_ok_nxt;
  logic [ELEM_W-1:0]  n_r, n_nxt;
  logic [COEF_AW-1:0] d_r, d_nxt;
  logic [ELEM_W-1:0]  cnt_r, cnt_nxt;
  logic [ELEM_W-1:0]  v_r, v_nxt;
  logic               rev_done_r, rev_done_nxt;
  logic               pend_r, pend_nxt;
  logic [ELEM_W-1:0]  pend_idx_r, pend_idx_nxt;
  logic [COEF_AW-1:0] i_r, i_nxt;
  logic [COEF_AW-1:0] j_r, j_nxt;
  logic [ELEM_W-1:0]  cur_r, cur_nxt;
  logic [ELEM_W-1:0]  prev_r, prev_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LOG_W-1:0]   out_log_r, out_log_nxt;
  logic [POW_W-1:0]   out_power_r, out_power_nxt;
  logic               out_status_r, out_status_nxt;
  logic               out_last_r, out_last_nxt;

  logic [T_W-1:0]     t_in;
  logic [M_W-1:0]     m_sel;
  logic [ELEM_W-1:0]  n_sel;
  logic [T_W:0]       d_sel;
  logic               t_invalid;
  logic [ELEM_W-1:0]  top_mask;
  logic [ELEM_W-1:0]  v_step;
  logic [ELEM_W:0]    mod_sum;
  logic [ELEM_W-1:0]  mod_res;
  logic [ELEM_W-1:0]  prod;
  logic               out_free;

  logic               pow_we, log_we, coef_we;
  logic [ELEM_W-1:0]  pow_waddr, pow_wdata, pow_raddr, pow_rdata;
  logic [ELEM_W-1:0]  log_waddr, log_wdata, log_raddr, log_rdata;
  logic [COEF_AW-1:0] coef_waddr, coef_raddr;
  logic [ELEM_W-1:0]  coef_wdata, coef_rdata;

  rsgp_ram #(.WIDTH(ELEM_W), .DEPTH(TBL_DEPTH)) u_pow_ram (
    .clk(clk), .we(pow_we), .waddr(pow_waddr), .wdata(pow_wdata),
    .raddr(pow_raddr), .rdata(pow_rdata)
  );

  rsgp_ram #(.WIDTH(ELEM_W), .DEPTH(TBL_DEPTH)) u_log_ram (
    .clk(clk), .we(log_we), .waddr(log_waddr), .wdata(log_wdata),
    .raddr(log_raddr), .rdata(log_rdata)
  );

  rsgp_ram #(.WIDTH(ELEM_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(coef_wdata),
    .raddr(coef_raddr), .rdata(coef_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_power_r, out_log_r});
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  assign t_in = in_tdata[T_W-1:0];

  always_comb begin
    if (fd_r < 3) begin
      m_sel = M_W'(3);
    end else if (fd_r > MAX_M) begin
      m_sel = M_W'(MAX_M);
    end else begin
      m_sel = M_W'(fd_r);
    end
    for (int k = 0; k < ELEM_W; k++) begin
      n_sel[k] = (k < int'(m_sel));
    end
    d_sel = {t_in, 1'b0};
    t_invalid = (t_in == '0) || (t_in > T_W'(MAX_T)) || (32'(d_sel) >= 32'(n_sel));
  end

  assign top_mask = n_r & ~(n_r >> 1);
  assign v_step   = ((v_r << 1) & n_r) ^ ((|(v_r & top_mask)) ? (ELEM_W'(pp_r) & n_r) : '0);

  always_comb begin
    mod_sum = {1'b0, log_rdata} + (ELEM_W + 1)'(i_r);
    if (mod_sum >= {1'b0, n_r}) begin
      mod_sum = mod_sum - {1'b0, n_r};
    end
    mod_res = mod_sum[ELEM_W-1:0];
  end

  assign prod = (cur_r == '0) ? '0 : pow_rdata;

  always_comb begin
    state_nxt      = state_r;
    fd_nxt         = fd_r;
    pp_nxt         = pp_r;
    tables_ok_nxt  = tables_ok_r;
    n_nxt          = n_r;
    d_nxt          = d_r;
    cnt_nxt        = cnt_r;
    v_nxt          = v_r;
    rev_done_nxt   = rev_done_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_log_nxt    = out_log_r;
    out_power_nxt  = out_power_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    pow_we     = 1'b0;
    pow_waddr  = cnt_r;
    pow_wdata  = v_r;
    pow_raddr  = '0;
    log_we     = 1'b0;
    log_waddr  = cnt_r;
    log_wdata  = '0;
    log_raddr  = '0;
    coef_we    = 1'b0;
    coef_waddr = j_r;
    coef_wdata = prev_r ^ prod;
    coef_raddr = '0;

    if (cfg_valid) begin
      tables_ok_nxt = 1'b0;
      case (cfg_index)
        REG_FIELD_DEGREE:   fd_nxt = cfg_data[FD_W-1:0];
        REG_PRIMITIVE_POLY: pp_nxt = cfg_data[PP_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_nxt   = n_sel;
          d_nxt   = COEF_AW'(d_sel);
          cnt_nxt = '0;
          v_nxt   = ELEM_W'(1);
          if (t_invalid) begin
            state_nxt = S_ERR;
          end else if (tables_ok_r) begin
            state_nxt = S_INIT;
          end else begin
            state_nxt = S_TFWD;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_log_nxt    = '0;
          out_power_nxt  = '0;
          out_status_nxt = 1'b1;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_TFWD: begin
        pow_we = (cnt_r != n_r);
        log_we = 1'b1;
        v_nxt  = v_step;
        if (cnt_r == n_r) begin
          cnt_nxt      = n_r - 1'b1;
          rev_done_nxt = 1'b0;
          pend_nxt     = 1'b0;
          state_nxt    = S_TREV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_TREV: begin
        pow_raddr = cnt_r;
        log_we    = pend_r;
        log_waddr = pow_rdata & n_r;
        log_wdata = pend_idx_r;
        if (!rev_done_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r;
          if (cnt_r == '0) begin
            rev_done_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            tables_ok_nxt = 1'b1;
            state_nxt     = S_INIT;
          end
        end
      end
      S_INIT: begin
        coef_we    = 1'b1;
        coef_waddr = '0;
        coef_wdata = ELEM_W'(2);
        i_nxt      = COEF_AW'(1);
        state_nxt  = S_ONE;
      end
      S_ONE: begin
        coef_we    = 1'b1;
        coef_waddr = i_r;
        coef_wdata = ELEM_W'(1);
        if (i_r == COEF_AW'(1)) begin
          i_nxt = COEF_AW'(2);
        end else begin
          j_nxt     = i_r - 1'b1;
          state_nxt = S_R0;
        end
      end
      S_R0: begin
        coef_raddr = j_r;
        state_nxt  = S_R1;
      end
      S_R1: begin
        cur_nxt    = coef_rdata;
        log_raddr  = coef_rdata & n_r;
        coef_raddr = j_r - 1'b1;
        state_nxt  = S_R2;
      end
      S_R2: begin
        prev_nxt  = (j_r == '0) ? '0 : coef_rdata;
        pow_raddr = mod_res;
        state_nxt = S_R3;
      end
      S_R3: begin
        coef_we = 1'b1;
        if (j_r != '0) begin
          j_nxt     = j_r - 1'b1;
          state_nxt = S_R0;
        end else if (i_r == d_r) begin
          j_nxt     = '0;
          state_nxt = S_E0;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_ONE;
        end
      end
      S_E0: begin
        coef_raddr = j_r;
        state_nxt  = S_E1;
      end
      S_E1: begin
        cur_nxt   = coef_rdata & n_r;
        log_raddr = coef_rdata & n_r;
        state_nxt = S_E2;
      end
      S_E2: begin
        log_raddr = cur_r;
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_log_nxt    = (cur_r == '0) ? '1 : LOG_W'(log_rdata);
          out_power_nxt  = POW_W'(j_r);
          out_status_nxt = 1'b0;
          out_last_nxt   = (j_r == d_r);
          if (j_r == d_r) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_E0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fd_r        <= FD_RESET;
      pp_r        <= PP_RESET;
      tables_ok_r <= 1'b0;
      rev_done_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fd_r        <= fd_nxt;
      pp_r        <= pp_nxt;
      tables_ok_r <= tables_ok_nxt;
      rev_done_r  <= rev_done_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    d_r          <= d_nxt;
    cnt_r        <= cnt_nxt;
    v_r          <= v_nxt;
    pend_idx_r   <= pend_idx_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    out_log_r    <= out_log_nxt;
    out_power_r  <= out_power_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Reed-Solomon generator polynomial builder.
// A clocked driver sends correction powers from a queue of requests, and a
// clocked monitor compares every coefficient item against a local GF(2^m)
// model of the product (x + a^1)...(x + a^2t). The field registers change
// only between phases while the block is idle. Both stream sides stall at
// random, with a final stretch without stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import rsgp_pkg::*;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_BAD_T = 1'b1;

  typedef struct packed {
    logic [LOG_W-1:0] coeff_log;
    logic [POW_W-1:0] coeff_power;
    logic             status;
    logic             last;
  } coeff_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [FD_W-1:0] field_deg = FD_RESET;
  logic [PP_W-1:0] prim_poly = PP_RESET;
  int pow_of [TBL_DEPTH];
  int log_of [TBL_DEPTH];
  int prim_by_m [3:10] = '{11, 19, 37, 67, 137, 285, 529, 1033};

  logic [T_W-1:0] t_requests [$];
  coeff_item_t coeff_expected [$];
  coeff_item_t want;
  coeff_item_t got;
  int send_idle_pct = 15;
  int recv_idle_pct = 68;
  bit failed = 1'b0;

  rs_generator_polynomial i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [5:0] correction_power
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [10:0] coeff_log, [16:11] coeff_power
    .out_tuser  (out_tuser),   // [0] status
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gf_scale(input int v, input int k, input int n);
    if (v == 0) return 0;
    return pow_of[((log_of[v & n] + k) % n) & n];
  endfunction

  function automatic void build_generator_poly(input logic [T_W-1:0] t);
    int m, n, d, lo, v, top, tt, c, i, j;
    int g [COEF_DEPTH];
    coeff_item_t item;
    m = field_deg;
    if (m < 3) m = 3;
    if (m > MAX_M) m = MAX_M;
    n = (1 << m) - 1;
    tt = t;
    if (tt < 1 || 2 * tt >= n || tt > MAX_T) begin
      item.coeff_log = '0;
      item.coeff_power = '0;
      item.status = STATUS_BAD_T;
      item.last = 1'b1;
      coeff_expected = {coeff_expected, item};
      return;
    end
    lo = prim_poly & n;
    v = 1;
    for (i = 0; i < n; i++) begin
      pow_of[i] = v;
      top = (v >> (m - 1)) & 1;
      v = ((v << 1) & n) ^ (top ? lo : 0);
    end
    for (i = 0; i < TBL_DEPTH; i++) log_of[i] = 0;
    // Walking down leaves the smallest exponent that reaches each element.
    for (i = n; i > 0; i--) log_of[pow_of[i - 1] & n] = i - 1;
    for (i = 0; i < COEF_DEPTH; i++) g[i] = 0;
    d = 2 * tt;
    g[0] = pow_of[1];
    g[1] = 1;
    for (i = 2; i <= d; i++) begin
      g[i] = 1;
      for (j = i - 1; j > 0; j--) g[j] = g[j - 1] ^ gf_scale(g[j], i, n);
      g[0] = gf_scale(g[0], i, n);
    end
    for (i = 0; i <= d; i++) begin
      c = g[i] & n;
      item.coeff_log = (c == 0) ? '1 : LOG_W'(log_of[c]);
      item.coeff_power = POW_W'(i);
      item.status = STATUS_OK;
      item.last = (i == d);
      coeff_expected = {coeff_expected, item};
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) build_generator_poly(in_tdata[T_W-1:0]);
      if (!in_tvalid || in_tready) begin
        if (t_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= IN_TDATA_W'(t_requests.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        got.coeff_log = out_tdata[LOG_W-1:0];
        got.coeff_power = out_tdata[LOG_W+POW_W-1:LOG_W];
        got.status = out_tuser;
        got.last = out_tlast;
        if (coeff_expected.size() == 0) begin
          failed = 1'b1;
          $display("%0t: unexpected item log %0d power %0d status %0b last %0b", $time,
                   $signed(got.coeff_log), got.coeff_power, got.status, got.last);
        end else begin
          want = coeff_expected.pop_front();
          if (got !== want) begin
            failed = 1'b1;
            $display({"%0t: expected log %0d power %0d status %0b last %0b,",
                      " actual log %0d power %0d status %0b last %0b"},
                     $time, $signed(want.coeff_log), want.coeff_power, want.status,
                     want.last, $signed(got.coeff_log), got.coeff_power, got.status,
                     got.last);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (t_requests.size() != 0 || in_tvalid || coeff_expected.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FIELD_DEGREE) field_deg = FD_W'(value);
    else prim_poly = PP_W'(value);
  endtask

  task automatic set_field(input int fd, input int pp);
    wait_drained();
    write_reg(REG_FIELD_DEGREE, fd);
    write_reg(REG_PRIMITIVE_POLY, pp);
  endtask

  task automatic random_segment(input int count);
    int fd, m, n, pp, tmax;
    fd = $urandom_range(0, 15);
    m = (fd < 3) ? 3 : (fd > MAX_M) ? MAX_M : fd;
    if ($urandom_range(0, 9) < 6)
      pp = (prim_by_m[m] | ($urandom_range(0, 2047) & ~((1 << (m + 1)) - 1))) & 2047;
    else
      pp = $urandom_range(0, 2047);
    set_field(fd, pp);
    n = (1 << m) - 1;
    tmax = ((n - 1) / 2 > MAX_T) ? MAX_T : (n - 1) / 2;
    repeat (count) begin
      if ($urandom_range(0, 3) != 0) t_requests = {t_requests, T_W'($urandom_range(1, tmax))};
      else t_requests = {t_requests, T_W'($urandom_range(0, 63))};
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset field: GF(2^8). Edge powers, both sides of MAX_T, every t bit.
    t_requests = '{6'd0, 6'd1, 6'd16, 6'd17, 6'd63, 6'd42, 6'd21};
    // Smallest field: only t up to 3 fits.
    set_field(3, 11);
    t_requests = '{6'd1, 6'd3, 6'd4, 6'd0};
    set_field(10, 1033);
    t_requests = '{6'd16, 6'd1};
    // Degree below range clamps to 3; bits above x^m are ignored.
    set_field(0, 2047);
    t_requests = '{6'd2, 6'd3};
    // Degree above range clamps to MAX_M with a degenerate polynomial.
    set_field(15, 0);
    t_requests = '{6'd5};
    set_field(4, 0);
    t_requests = '{6'd7, 6'd1};
    set_field(5, 1234);
    t_requests = '{6'd3};

    for (int seg = 0; seg < 9; seg++) begin
      wait_drained();
      if (seg == 3) begin
        send_idle_pct = 68;
        recv_idle_pct = 15;
      end else if (seg == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_segment(20);
    end

    wait_drained();
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ rs_generator_polynomial.f @@
design/rsgp_pkg.sv
design/rsgp_ram.sv
design/rs_generator_polynomial.sv
sim/tb_top.sv
